// ----- hw/rtl/bmsf_pkg.sv -----
package bmsf_pkg;

    localparam int MAX_LINE  = 256;
    localparam int COL_W     = $clog2(MAX_LINE);
    localparam int LEN_W     = COL_W + 1;
    localparam int CNT_W     = 12;
    localparam int ILINE_W   = CNT_W + 1;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 1'b1;

    localparam logic [LEN_W-1:0] LINE_LENGTH_RST = LEN_W'(90);
    localparam logic [CNT_W-1:0] LINE_COUNT_RST  = CNT_W'(180);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // window threshold: wall when more than this many walls
    localparam int MAJ_LIMIT = 4;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             filling;
        logic             in_wall;
        logic             primed;
        logic             left_ok;
        logic             right_ok;
        logic             top_ok;
        logic             bottom_ok;
        logic             eol;
        logic             eof;
    } op_t;

    typedef struct packed {
        logic wall;
        logic eol;
        logic eof;
    } res_t;

endpackage

// ----- hw/rtl/binary_majority_smoothing_filter_core.sv -----
// One 3x3 majority smoothing pass over a binary wall map streamed in raster
// order (1 = wall). Cells outside the map count as walls; a result is a wall
// when more than four of the nine window cells are walls. Set line_length
// (index 0, 1..256) and line_count (index 1, 1..4095) while idle. The block
// takes one item per clock through push/full, while full is low, and
// delivers results through empty/pop; results trail the input by one line
// plus one cell, so after the last cell of the map push line_length + 1
// drain items (kind = 1) to flush it. A cell pushed after the frame ended
// but before its last result acts as a drain. A result passes through the
// op queue, the registered read of the line store and the result queue
// before it is on the outputs.
module binary_majority_smoothing_filter_core
    import bmsf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  logic                 kind,
    input  logic                 cell_in,
    output logic                 empty,
    input  logic                 pop,
    output logic                 cell_out,
    output logic                 end_of_line,
    output logic                 end_of_frame
);

    logic [LEN_W-1:0] line_length_reg;
    logic [CNT_W-1:0] line_count_reg;

    logic op_valid;
    op_t  front_op;
    op_t  q_op;
    logic q_full;
    logic q_empty;
    logic q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= LINE_LENGTH_RST;
            line_count_reg  <= LINE_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_LINE_LENGTH: line_length_reg <= cfg_wdata[LEN_W-1:0];
                REG_LINE_COUNT:  line_count_reg  <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign full = q_full;

    bmsf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_length (line_length_reg),
        .line_count  (line_count_reg),
        .push        (push),
        .kind        (kind),
        .cell_in     (cell_in),
        .q_full      (q_full),
        .op_valid    (op_valid),
        .op          (front_op)
    );

    bmsf_op_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (op_valid),
        .op_in  (front_op),
        .full   (q_full),
        .pop    (q_pop),
        .op_out (q_op),
        .empty  (q_empty)
    );

    bmsf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_op         (q_op),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .cell_out     (cell_out),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid |-> !q_full)
        else $error("front pushed into a full op queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back popped an empty op queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && q_empty) |=> !q_empty)
        else $error("op transfer into empty queue was lost");

endmodule

// ----- hw/rtl/bmsf_front.sv -----
module bmsf_front
    import bmsf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LEN_W-1:0] line_length,
    input  logic [CNT_W-1:0] line_count,
    input  logic             push,
    input  logic             kind,
    input  logic             cell_in,
    input  logic             q_full,
    output logic             op_valid,
    output op_t              op
);

    logic [COL_W-1:0]   in_col_reg;
    logic [ILINE_W-1:0] in_line_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [CNT_W-1:0]   out_line_reg;

    logic [LEN_W-1:0]   len_eff;
    logic [CNT_W-1:0]   cnt_eff;
    logic [ILINE_W-1:0] cnt_ext;
    logic               filling;
    logic [COL_W-1:0]   col;
    logic [LEN_W-1:0]   col_inc;
    logic               wrap;
    logic               primed;
    logic [LEN_W-1:0]   oc_inc;
    logic [ILINE_W-1:0] ol_inc;
    logic               eol;
    logic               eof;
    logic               take;
    logic               drop;

    always_comb
    begin
        len_eff = line_length;
        if (line_length == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (line_length > LEN_W'(MAX_LINE))
        begin
            len_eff = LEN_W'(MAX_LINE);
        end
        cnt_eff = (line_count == '0) ? CNT_W'(1) : line_count;
        cnt_ext = {1'b0, cnt_eff};

        filling = in_line_reg < cnt_ext;
        col     = ({1'b0, in_col_reg} >= len_eff) ? '0 : in_col_reg;
        col_inc = {1'b0, col} + LEN_W'(1);
        wrap    = col_inc >= len_eff;
        primed  = (in_line_reg >= ILINE_W'(2))
                  || (in_line_reg == ILINE_W'(1) && col != '0);

        oc_inc = {1'b0, out_col_reg} + LEN_W'(1);
        ol_inc = {1'b0, out_line_reg} + ILINE_W'(1);
        eol    = oc_inc >= len_eff;
        eof    = eol && (ol_inc >= cnt_ext);

        take     = push && !q_full;
        drop     = kind && filling;
        op_valid = take && !drop;

        op.col       = col;
        op.filling   = filling;
        op.in_wall   = cell_in;
        op.primed    = primed;
        op.left_ok   = out_col_reg != '0;
        op.right_ok  = oc_inc < len_eff;
        op.top_ok    = out_line_reg != '0;
        op.bottom_ok = ol_inc < cnt_ext;
        op.eol       = eol;
        op.eof       = eof;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_line_reg  <= '0;
            out_col_reg  <= '0;
            out_line_reg <= '0;
        end
        else if (op_valid)
        begin
            if (primed && eof)
            begin
                in_col_reg   <= '0;
                in_line_reg  <= '0;
                out_col_reg  <= '0;
                out_line_reg <= '0;
            end
            else
            begin
                in_col_reg <= wrap ? '0 : col_inc[COL_W-1:0];
                if (wrap && in_line_reg <= cnt_ext)
                begin
                    in_line_reg <= in_line_reg + ILINE_W'(1);
                end
                if (primed)
                begin
                    if (eol)
                    begin
                        out_col_reg  <= '0;
                        out_line_reg <= ol_inc[CNT_W-1:0];
                    end
                    else
                    begin
                        out_col_reg <= oc_inc[COL_W-1:0];
                    end
                end
            end
        end
    end

endmodule

// ----- hw/rtl/bmsf_op_queue.sv -----
module bmsf_op_queue
    import bmsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  op_in,
    output logic full,
    input  logic pop,
    output op_t  op_out,
    output logic empty
);

    op_t                q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = count_reg == Q_CNT_W'(Q_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign op_out  = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/bmsf_back.sv -----
module bmsf_back
    import bmsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  op_t  q_op,
    output logic q_pop,
    output logic empty,
    input  logic pop,
    output logic cell_out,
    output logic end_of_line,
    output logic end_of_frame
);

    // line store entry: {upper, middle}
    logic [1:0]         store_mem [MAX_LINE];
    logic [1:0]         rdata_reg;
    op_t                op1_reg;
    logic               valid1_reg;

    logic               byp_valid_reg;
    logic [COL_W-1:0]   byp_addr_reg;
    logic [1:0]         byp_data_reg;

    logic [8:0]         window_reg;

    res_t               out_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] out_wr_reg;
    logic [Q_PTR_W-1:0] out_rd_reg;
    logic [Q_CNT_W-1:0] out_count_reg;

    logic [1:0]         entry;
    logic               up;
    logic               mid;
    logic               bot;
    logic [8:0]         win_new;
    logic [8:0]         terms;
    logic [3:0]         walls;
    logic               wr_en;
    logic               res_push;
    res_t               res;
    logic               out_pop;
    res_t               head;

    assign q_pop = !q_empty
                   && ((out_count_reg + Q_CNT_W'(valid1_reg)) < Q_CNT_W'(Q_DEPTH));

    always_comb
    begin
        entry = (byp_valid_reg && byp_addr_reg == op1_reg.col) ? byp_data_reg : rdata_reg;
        up    = entry[1];
        mid   = entry[0];
        bot   = op1_reg.filling & op1_reg.in_wall;
        win_new = {window_reg[5:0], bot, mid, up};

        // left column in bits 8:6, right column in bits 2:0; row 0 is the top
        terms[8] = (op1_reg.left_ok  && op1_reg.bottom_ok) ? win_new[8] : 1'b1;
        terms[7] =  op1_reg.left_ok                        ? win_new[7] : 1'b1;
        terms[6] = (op1_reg.left_ok  && op1_reg.top_ok)    ? win_new[6] : 1'b1;
        terms[5] =  op1_reg.bottom_ok                      ? win_new[5] : 1'b1;
        terms[4] =  win_new[4];
        terms[3] =  op1_reg.top_ok                         ? win_new[3] : 1'b1;
        terms[2] = (op1_reg.right_ok && op1_reg.bottom_ok) ? win_new[2] : 1'b1;
        terms[1] =  op1_reg.right_ok                       ? win_new[1] : 1'b1;
        terms[0] = (op1_reg.right_ok && op1_reg.top_ok)    ? win_new[0] : 1'b1;
        walls    = 4'($countones(terms));

        res.wall = walls > 4'(MAJ_LIMIT);
        res.eol  = op1_reg.eol;
        res.eof  = op1_reg.eof;

        wr_en    = valid1_reg && op1_reg.filling;
        res_push = valid1_reg && op1_reg.primed;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op1_reg   <= q_op;
            rdata_reg <= store_mem[q_op.col];
        end
        if (wr_en)
        begin
            store_mem[op1_reg.col] <= {mid, op1_reg.in_wall};
            byp_addr_reg           <= op1_reg.col;
            byp_data_reg           <= {mid, op1_reg.in_wall};
        end
        if (res_push)
        begin
            out_mem[out_wr_reg] <= res;
        end
    end

    assign empty   = out_count_reg == '0;
    assign out_pop = pop && !empty;
    assign head    = out_mem[out_rd_reg];
    assign cell_out     = head.wall;
    assign end_of_line  = head.eol;
    assign end_of_frame = head.eof;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            byp_valid_reg <= 1'b0;
            window_reg    <= '0;
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            valid1_reg <= q_pop;
            if (wr_en)
            begin
                byp_valid_reg <= 1'b1;
            end
            if (valid1_reg)
            begin
                window_reg <= win_new;
            end
            if (res_push)
            begin
                out_wr_reg <= out_wr_reg + Q_PTR_W'(1);
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + Q_PTR_W'(1);
            end
            if (res_push && !out_pop)
            begin
                out_count_reg <= out_count_reg + Q_CNT_W'(1);
            end
            else if (out_pop && !res_push)
            begin
                out_count_reg <= out_count_reg - Q_CNT_W'(1);
            end
        end
    end

endmodule

// ----- verif/binary_majority_smoothing_filter_core_test.sv -----
`timescale 1ns / 1ps

class smoothed_map_scoreboard;

    logic [bmsf_pkg::LEN_W-1:0] span_reg;
    logic [bmsf_pkg::CNT_W-1:0] depth_reg;
    bit                         upper_row [bmsf_pkg::MAX_LINE];
    bit                         middle_row[bmsf_pkg::MAX_LINE];
    logic [8:0]                 window;
    int unsigned                in_col;
    int unsigned                in_line;
    int unsigned                out_col;
    int unsigned                out_line;
    bmsf_pkg::res_t             smoothed_cells_q[$];
    int unsigned                errors;

    function new();
        span_reg  = bmsf_pkg::LINE_LENGTH_RST;
        depth_reg = bmsf_pkg::LINE_COUNT_RST;
        window    = '0;
        in_col    = 0;
        in_line   = 0;
        out_col   = 0;
        out_line  = 0;
        errors    = 0;
    endfunction

    function void set_reg(logic [bmsf_pkg::CFG_IDX_W-1:0] idx,
                          logic [bmsf_pkg::CFG_W-1:0] val);
        if (idx == bmsf_pkg::REG_LINE_LENGTH)
            span_reg = val[bmsf_pkg::LEN_W-1:0];
        else
            depth_reg = val[bmsf_pkg::CNT_W-1:0];
    endfunction

    function int unsigned span();
        if (span_reg == 0)
            return 1;
        if (span_reg > bmsf_pkg::MAX_LINE)
            return bmsf_pkg::MAX_LINE;
        return span_reg;
    endfunction

    function int unsigned depth();
        return (depth_reg == 0) ? 1 : depth_reg;
    endfunction

    function bit busy();
        return (in_line != 0) || (in_col != 0);
    endfunction

    function bit awaiting_cells();
        return in_line < depth();
    endfunction

    function int unsigned outstanding();
        return smoothed_cells_q.size();
    endfunction

    function void accept_item(logic kind, logic wall_in);
        int unsigned    len;
        int unsigned    cnt;
        int unsigned    ic;
        int unsigned    r;
        int unsigned    c;
        int unsigned    walls;
        int             i;
        int             j;
        logic           filling;
        logic           primed;
        logic           top;
        logic           mid;
        logic           bot;
        logic           col_ok;
        logic           row_ok;
        bmsf_pkg::res_t res;

        len     = span();
        cnt     = depth();
        filling = in_line < cnt;
        if (kind && filling)
            return;
        if (in_col >= len)
            in_col = 0;
        ic  = in_col;
        top = upper_row[ic];
        mid = middle_row[ic];
        bot = filling ? wall_in : 1'b0;
        if (filling)
        begin
            upper_row[ic]  = mid;
            middle_row[ic] = wall_in;
        end
        primed = (in_line >= 2) || (in_line == 1 && ic >= 1);
        window = {window[5:0], bot, mid, top};

        if (ic + 1 >= len)
        begin
            in_col = 0;
            if (in_line <= cnt)
                in_line++;
        end
        else
        begin
            in_col = ic + 1;
        end
        if (!primed)
            return;

        r     = out_line;
        c     = out_col;
        walls = 0;
        // window columns: oldest (left) in the top bits; rows: upper, middle, lower
        for (i = 0; i < 3; i++)
        begin
            for (j = 0; j < 3; j++)
            begin
                col_ok = (i == 0) ? (c > 0) : (i == 2) ? (c + 1 < len) : 1'b1;
                row_ok = (j == 0) ? (r > 0) : (j == 2) ? (r + 1 < cnt) : 1'b1;
                walls += (col_ok && row_ok) ? window[(2 - i) * 3 + j] : 1;
            end
        end

        res.eol  = (c + 1 >= len);
        res.eof  = res.eol && (r + 1 >= cnt);
        res.wall = (walls > bmsf_pkg::MAJ_LIMIT);
        smoothed_cells_q.push_back(res);

        if (res.eof)
        begin
            in_col   = 0;
            in_line  = 0;
            out_col  = 0;
            out_line = 0;
        end
        else if (res.eol)
        begin
            out_col  = 0;
            out_line = r + 1;
        end
        else
        begin
            out_col = c + 1;
        end
    endfunction

    function void check_smoothed_cell(logic wall, logic eol, logic eof);
        bmsf_pkg::res_t want;

        if (smoothed_cells_q.size() == 0)
        begin
            $error("result transfer with nothing expected: cell_out %b eol %b eof %b",
                   wall, eol, eof);
            errors++;
            return;
        end
        want = smoothed_cells_q.pop_front();
        if (wall !== want.wall)
        begin
            $error("cell_out: expected %b, actual %b", want.wall, wall);
            errors++;
        end
        if (eol !== want.eol)
        begin
            $error("end_of_line: expected %b, actual %b", want.eol, eol);
            errors++;
        end
        if (eof !== want.eof)
        begin
            $error("end_of_frame: expected %b, actual %b", want.eof, eof);
            errors++;
        end
    endfunction

endclass

module binary_majority_smoothing_filter_core_test;

    import bmsf_pkg::*;

    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;
    localparam logic CELL_OPEN  = 1'b0;
    localparam logic CELL_WALL  = 1'b1;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   CYCLE_LIMIT   = 500000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 push      = 1'b0;
    logic                 full;
    logic                 kind      = 1'b0;
    logic                 cell_in   = 1'b0;
    logic                 empty;
    logic                 pop       = 1'b0;
    logic                 cell_out;
    logic                 end_of_line;
    logic                 end_of_frame;

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned cycles    = 0;

    smoothed_map_scoreboard sb = new();

    binary_majority_smoothing_filter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .cell_in      (cell_in),
        .empty        (empty),
        .pop          (pop),
        .cell_out     (cell_out),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("binary_majority_smoothing_filter_core_test: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check_smoothed_cell(cell_out, end_of_line, end_of_frame);

    // entered and left at a falling edge; push stays high after the transfer
    task automatic send_item(input logic k, input logic c);
        while ($urandom_range(99) < send_idle)
        begin
            push    <= 1'b0;
            kind    <= ($urandom_range(1) != 0);
            cell_in <= ($urandom_range(1) != 0);
            @(negedge clk);
        end
        push    <= 1'b1;
        kind    <= k;
        cell_in <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.accept_item(k, c);
        @(negedge clk);
    endtask

    task automatic quiesce();
        push <= 1'b0;
        do
            @(negedge clk);
        while (sb.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge clk);
        sb.set_reg(idx, CFG_W'(val));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input int unsigned len, input int unsigned cnt);
        quiesce();
        write_reg(REG_LINE_LENGTH, len);
        write_reg(REG_LINE_COUNT, cnt);
    endtask

    task automatic run_frame(input int unsigned wall_pct, inout int unsigned sent);
        do
        begin
            if ($urandom_range(99) < 5)
                send_item(KIND_DRAIN, $urandom_range(1) != 0);
            else
            begin
                send_item(KIND_CELL, $urandom_range(99) < wall_pct);
                sent++;
            end
        end
        while (sb.awaiting_cells());
        // flush; some cells land after the frame and act as drains
        while (sb.busy())
        begin
            if ($urandom_range(99) < 20)
                send_item(KIND_CELL, $urandom_range(1) != 0);
            else
                send_item(KIND_DRAIN, $urandom_range(1) != 0);
            sent++;
        end
    endtask

    initial
    begin
        logic [8:0]  pattern;
        int          i;
        int          phase;
        int unsigned sent;
        int unsigned len;
        int unsigned cnt;
        int unsigned pick;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle = 35;
        recv_idle = 71;

        // 3x3 map; center window holds exactly four walls
        pattern = 9'b001010101;
        set_config(12'hE03, 3);
        send_item(KIND_DRAIN, CELL_WALL);
        for (i = 0; i < 9; i++)
        begin
            send_item(KIND_CELL, pattern[i]);
            if (i == 4)
                send_item(KIND_DRAIN, CELL_OPEN);
        end
        send_item(KIND_DRAIN, CELL_OPEN);
        send_item(KIND_CELL, CELL_WALL);
        while (sb.busy())
            send_item(KIND_DRAIN, CELL_WALL);

        // zero registers act as a 1x1 map
        set_config(0, 0);
        send_item(KIND_CELL, CELL_OPEN);
        while (sb.busy())
            send_item(KIND_DRAIN, CELL_OPEN);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 35;
                    recv_idle = 71;
                end
                1:
                begin
                    send_idle = 71;
                    recv_idle = 35;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            sent = 0;
            while (sent < 130)
            begin
                if ($urandom_range(99) < 70)
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        len = 0;
                    else
                        len = $urandom_range(12, 1);
                    cnt = ($urandom_range(99) < 5) ? 0 : $urandom_range(8, 1);
                    set_config(len, cnt);
                end
                run_frame($urandom_range(100), sent);
            end
            case (phase)
                0:       set_config(40, 2);
                1:       set_config(1, 40);
                default: set_config(2, 12);
            endcase
            run_frame($urandom_range(100), sent);
        end

        quiesce();
        if (sb.errors == 0)
            $display("binary_majority_smoothing_filter_core_test: done, clean");
        else
            $display("binary_majority_smoothing_filter_core_test: done, errors");
        $finish;
    end

endmodule
